[hw/rtl/tcch_pkg.sv]
// ----------------------------------------------------------------------------
// tcch_pkg
// Types, constants and helper functions of the tilt-compensated compass core.
// ----------------------------------------------------------------------------
package tcch_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int HEAD_W          = 15;
  localparam int SQRT_STEPS      = 15;
  localparam int CORDIC_STEPS    = 23;
  localparam int XY_W            = 48;
  localparam int Z_W             = 28;
  localparam int ROOT_W          = 30;

  localparam logic signed [15:0]  ONE_G   = 16'sd16384;
  localparam logic signed [Z_W-1:0] Z_90  = 28'sd5898240;
  localparam logic signed [Z_W-1:0] Z_180 = 28'sd11796480;
  localparam logic signed [Z_W-1:0] Z_360 = 28'sd23592960;
  localparam logic [Z_W-1:0] RND_HALF = 28'(1) << (15 - ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic signed [15:0] sp;
    logic signed [15:0] sr;
  } sample_t;

  typedef struct packed {
    sample_t           smp;
    logic [ROOT_W-1:0] vp;
    logic [ROOT_W-1:0] rp;
    logic [ROOT_W-1:0] vr;
    logic [ROOT_W-1:0] rr;
  } sqrt_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   spec;
    logic signed [Z_W-1:0]  zs;
  } cordic_t;

  function automatic logic signed [15:0] clamp_g(logic signed [15:0] a);
    if (a > ONE_G) return ONE_G;
    if (a < -ONE_G) return -ONE_G;
    return a;
  endfunction

  // one restoring step of the integer square root: {v, r}
  function automatic logic [2*ROOT_W-1:0] isqrt_step(logic [ROOT_W-1:0] v,
                                                     logic [ROOT_W-1:0] r,
                                                     logic [ROOT_W-1:0] b);
    logic [ROOT_W-1:0] t;
    t = r + b;
    if (v >= t) return {v - t, (r >> 1) + b};
    return {v, r >> 1};
  endfunction

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_tab(logic [4:0] i);
    case (i)
      5'd0:    return 28'sd2949120;
      5'd1:    return 28'sd1740967;
      5'd2:    return 28'sd919879;
      5'd3:    return 28'sd466945;
      5'd4:    return 28'sd234379;
      5'd5:    return 28'sd117304;
      5'd6:    return 28'sd58666;
      5'd7:    return 28'sd29335;
      5'd8:    return 28'sd14668;
      5'd9:    return 28'sd7334;
      5'd10:   return 28'sd3667;
      5'd11:   return 28'sd1833;
      5'd12:   return 28'sd917;
      5'd13:   return 28'sd458;
      5'd14:   return 28'sd229;
      5'd15:   return 28'sd115;
      5'd16:   return 28'sd57;
      5'd17:   return 28'sd29;
      5'd18:   return 28'sd14;
      5'd19:   return 28'sd7;
      5'd20:   return 28'sd4;
      5'd21:   return 28'sd2;
      5'd22:   return 28'sd1;
      default: return 28'sd0;
    endcase
  endfunction

endpackage

[hw/rtl/tcch_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// tcch_sqrt_cell
// One bit-pair step of the cosine square roots, pitch and roll lanes.
// ----------------------------------------------------------------------------
module tcch_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [3:0]     step_i,
  input  tcch_pkg::sqrt_t d_i,
  output logic           vld_o,
  output tcch_pkg::sqrt_t d_o
);
  import tcch_pkg::*;

  logic [ROOT_W-1:0]   bit_w;
  logic [2*ROOT_W-1:0] res_p, res_r;
  sqrt_t               d_d, d_q;
  logic                vld_q;

  assign bit_w = ROOT_W'(1) << (5'd28 - {step_i, 1'b0});

  always_comb begin
    res_p   = isqrt_step(d_i.vp, d_i.rp, bit_w);
    res_r   = isqrt_step(d_i.vr, d_i.rr, bit_w);
    d_d     = d_i;
    d_d.vp  = res_p[2*ROOT_W-1:ROOT_W];
    d_d.rp  = res_p[ROOT_W-1:0];
    d_d.vr  = res_r[2*ROOT_W-1:ROOT_W];
    d_d.rr  = res_r[ROOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign vld_o = vld_q;
  assign d_o   = d_q;

endmodule

[hw/rtl/tcch_cordic_cell.sv]
// ----------------------------------------------------------------------------
// tcch_cordic_cell
// One CORDIC vectoring micro-rotation with its angle accumulation.
// ----------------------------------------------------------------------------
module tcch_cordic_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [4:0]       step_i,
  input  tcch_pkg::cordic_t d_i,
  output logic             vld_o,
  output tcch_pkg::cordic_t d_o
);
  import tcch_pkg::*;

  logic signed [XY_W-1:0] dx, dy;
  cordic_t                d_d, d_q;
  logic                   vld_q;

  assign dx = d_i.y >>> step_i;
  assign dy = d_i.x >>> step_i;

  always_comb begin
    d_d = d_i;
    if (d_i.y > 0) begin
      d_d.x = d_i.x + dx;
      d_d.y = d_i.y - dy;
      d_d.z = d_i.z + atan_tab(step_i);
    end else begin
      d_d.x = d_i.x - dx;
      d_d.y = d_i.y + dy;
      d_d.z = d_i.z - atan_tab(step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign vld_o = vld_q;
  assign d_o   = d_q;

endmodule

[hw/rtl/tilt_compensated_compass_heading_core.sv]
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_core
// Tilt-compensated magnetic heading from raw magnetometer and accelerometer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one sample request: three
//   magnetometer counts and X/Y acceleration (16384 = 1 g). Output channel
//   (out_valid_o / out_ready_i) returns heading + 180 deg in 1/64 degree.
//   The pipeline holds the input clamp register, 15 square-root cells, two
//   multiply stages, 23 CORDIC cells and the output register.
//   One request per cycle unless stalled; the cell chains are fully pipelined.
//   The whole chain advances while the output register is empty or being
//   taken; when the receiver stalls with a result held, the chain freezes
//   and in_ready_o drops until out_ready_i returns.
//   Reset clears all valid flags; no request is in flight after reset.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [15:0]          mag_x_i,
  input  logic signed [15:0]          mag_y_i,
  input  logic signed [15:0]          mag_z_i,
  input  logic signed [15:0]          acc_x_i,
  input  logic signed [15:0]          acc_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcch_pkg::HEAD_W-1:0] heading_o
);
  import tcch_pkg::*;

  typedef struct packed {
    logic signed [31:0] p1;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [15:0] sr;
    logic signed [15:0] cp;
  } mul_t;

  logic en;
  logic out_vld_q;
  logic [HEAD_W-1:0] head_q, head_d;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // input register; acceleration saturated to +-1 g
  sample_t a_q;
  logic    a_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q.mx <= mag_x_i;
      a_q.my <= mag_y_i;
      a_q.mz <= mag_z_i;
      a_q.sp <= clamp_g(acc_x_i);
      a_q.sr <= clamp_g(acc_y_i);
    end
  end

  // square-root chain: cos = floor(sqrt(2^28 - s^2))
  sqrt_t sq_d [SQRT_STEPS+1];
  logic  sq_v [SQRT_STEPS+1];
  logic signed [31:0] sqp, sqr;

  assign sqp = a_q.sp * a_q.sp;
  assign sqr = a_q.sr * a_q.sr;

  always_comb begin
    sq_d[0].smp = a_q;
    sq_d[0].vp  = ROOT_W'(32'sd268435456 - sqp);
    sq_d[0].rp  = '0;
    sq_d[0].vr  = ROOT_W'(32'sd268435456 - sqr);
    sq_d[0].rr  = '0;
  end
  assign sq_v[0] = a_vld_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tcch_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_v[k]),
      .step_i (4'(k)),
      .d_i    (sq_d[k]),
      .vld_o  (sq_v[k+1]),
      .d_o    (sq_d[k+1])
    );
  end

  // first multiply stage
  sqrt_t sq_l;
  logic signed [15:0] cp, cr;
  mul_t m1_q;
  logic m1_vld_q;
  logic m2_vld_q;

  assign sq_l = sq_d[SQRT_STEPS];
  assign cp   = $signed({1'b0, sq_l.rp[14:0]});
  assign cr   = $signed({1'b0, sq_l.rr[14:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= sq_v[SQRT_STEPS];
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q.p1 <= sq_l.smp.mx * sq_l.smp.sp;
      m1_q.a  <= sq_l.smp.mx * cp;
      m1_q.b  <= sq_l.smp.mz * sq_l.smp.sp;
      m1_q.c  <= sq_l.smp.my * cr;
      m1_q.d  <= sq_l.smp.mz * sq_l.smp.sr;
      m1_q.sr <= sq_l.smp.sr;
      m1_q.cp <= cp;
    end
  end

  // second multiply stage: horizontal-plane vector
  logic signed [XY_W-1:0] xh_q, yh_q;
  logic signed [XY_W-1:0] t1, t3, sab;

  assign t1  = m1_q.p1 * m1_q.sr;
  assign t3  = m1_q.d * m1_q.cp;
  assign sab = XY_W'(m1_q.a) + XY_W'(m1_q.b);

  always_ff @(posedge clk_i) begin
    if (en) begin
      xh_q <= sab <<< 14;
      yh_q <= t1 + (XY_W'(m1_q.c) <<< 14) - t3;
    end
  end

  // quadrant folding and axis cases ahead of the CORDIC chain
  cordic_t cd_d [CORDIC_STEPS+1];
  logic    cd_v [CORDIC_STEPS+1];

  always_comb begin
    cd_d[0].x    = xh_q;
    cd_d[0].y    = yh_q;
    cd_d[0].z    = '0;
    cd_d[0].spec = 1'b0;
    cd_d[0].zs   = '0;
    if (yh_q == 0) begin
      cd_d[0].spec = 1'b1;
      cd_d[0].zs   = (xh_q < 0) ? Z_180 : '0;
    end else if (xh_q == 0) begin
      cd_d[0].spec = 1'b1;
      cd_d[0].zs   = (yh_q > 0) ? Z_90 : -Z_90;
    end else if (xh_q < 0) begin
      cd_d[0].x = -xh_q;
      cd_d[0].y = -yh_q;
      cd_d[0].z = (yh_q > 0) ? Z_180 : -Z_180;
    end
  end
  assign cd_v[0] = m2_vld_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    tcch_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (cd_v[k]),
      .step_i (5'(k)),
      .d_i    (cd_d[k]),
      .vld_o  (cd_v[k+1]),
      .d_o    (cd_d[k+1])
    );
  end

  // offset by 180 deg, clamp to 0..360 deg, round half up
  cordic_t            cd_l;
  logic signed [Z_W:0] h;
  logic [Z_W-1:0]     hu, hr;

  assign cd_l = cd_d[CORDIC_STEPS];

  always_comb begin
    h = (cd_l.spec ? (Z_W+1)'(cd_l.zs) : (Z_W+1)'(cd_l.z)) + (Z_W+1)'(Z_180);
    if (h < 0) begin
      hu = '0;
    end else if (h > (Z_W+1)'(Z_360)) begin
      hu = Z_W'(Z_360);
    end else begin
      hu = h[Z_W-1:0];
    end
    hr     = (hu + RND_HALF) >> (16 - ANGLE_FRAC_BITS);
    head_d = hr[HEAD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      head_q <= head_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign heading_o   = head_q;

endmodule

[hw/rtl/tcch_checker.sv]
// ----------------------------------------------------------------------------
// tcch_checker
// Port-level checks of the compass heading core, bound to the top level.
// ----------------------------------------------------------------------------
module tcch_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tcch_pkg::HEAD_W-1:0] heading_o
);
  import tcch_pkg::*;

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(heading_o))
    else $error("heading changed while stalled");

  // heading never beyond 360 deg
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_o <= HEAD_W'(360 << ANGLE_FRAC_BITS))
    else $error("heading out of range");

  // a receiver that takes results never backs up the input
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with receiver ready");

endmodule

bind tilt_compensated_compass_heading_core tcch_checker u_tcch_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .heading_o   (heading_o)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt-compensated compass heading core: random
// and corner samples go in, each heading is checked against a bit-exact
// integer model of square root, plane rotation and CORDIC atan2.
// ----------------------------------------------------------------------------
module tb_top;
  import tcch_pkg::*;

  typedef struct {
    logic signed [15:0] mx, my, mz, ax, ay;
  } smp_req_t;

  localparam longint DEG = 65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] mag_x_i = '0, mag_y_i = '0, mag_z_i = '0, acc_x_i = '0, acc_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [HEAD_W-1:0] heading_o;

  smp_req_t pend_q[$];
  logic [HEAD_W-1:0] heading_exp_q[$];
  int err_cnt = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;
  int burst_left = 0, gap_left = 0;

  tilt_compensated_compass_heading_core dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint sq_root(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint sat_g(logic signed [15:0] a);
    longint v;
    v = a;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                        29, 14, 7, 4, 2, 1};
    return tab[i];
  endfunction

  // atan2 in 2^-16 degree; >>> on longint is a floor shift
  function automatic longint atan2_fix(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? 180 * DEG : 0;
    if (x == 0) return (y > 0) ? 90 * DEG : -90 * DEG;
    if (x < 0) begin
      z = (y > 0) ? 180 * DEG : -180 * DEG;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 23; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic logic [HEAD_W-1:0] heading_of(smp_req_t s);
    longint mx, my, mz, sp, sr, cp, cr, xh, yh, h;
    mx = s.mx; my = s.my; mz = s.mz;
    sp = sat_g(s.ax);
    sr = sat_g(s.ay);
    cp = sq_root(16384 * 16384 - sp * sp);
    cr = sq_root(16384 * 16384 - sr * sr);
    xh = (mx * cp + mz * sp) * 16384;
    yh = mx * sr * sp + my * cr * 16384 - mz * sr * cp;
    h = atan2_fix(yh, xh) + 180 * DEG;
    if (h < 0) h = 0;
    if (h > 360 * DEG) h = 360 * DEG;
    h = (h + (64'sd1 <<< (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
    return h[HEAD_W-1:0];
  endfunction

  task automatic report_err(string what);
    err_cnt++;
    if (err_cnt <= 30) $display("ERROR %0t: %s", $realtime, what);
  endtask

  task automatic push_req(int mx, int my, int mz, int ax, int ay);
    smp_req_t s;
    s.mx = 16'(mx); s.my = 16'(my); s.mz = 16'(mz); s.ax = 16'(ax); s.ay = 16'(ay);
    pend_q.push_back(s);
  endtask

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rnd_acc();
    case ($urandom_range(0, 5))
      0: return rnd16();
      1: return $urandom_range(0, 1) ? 16384 : -16384;
      2: return int'($urandom_range(0, 16)) - 8;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // driver: bursts and gaps, held during a drain request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // keep request stable
      end else begin
        if (in_valid_i) void'(pend_q.pop_front());
        if (pend_q.size() == 0 || hold_req) begin
          in_valid_i <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          mag_x_i <= pend_q[0].mx; mag_y_i <= pend_q[0].my; mag_z_i <= pend_q[0].mz;
          acc_x_i <= pend_q[0].ax; acc_y_i <= pend_q[0].ay;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      smp_req_t s;
      s.mx = mag_x_i; s.my = mag_y_i; s.mz = mag_z_i; s.ax = acc_x_i; s.ay = acc_y_i;
      heading_exp_q.push_back(heading_of(s));
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0: out_ready_i <= ($urandom_range(0, 3) != 0);
          1: out_ready_i <= 1'b1;
          default: out_ready_i <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (heading_exp_q.size() == 0) begin
        report_err($sformatf("unexpected heading %0d", heading_o));
      end else begin
        logic [HEAD_W-1:0] e;
        e = heading_exp_q.pop_front();
        if (heading_o !== e)
          report_err($sformatf("heading got %0d exp %0d", heading_o, e));
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int wait_cnt;
    // directed corners: extremes, saturation, zero vectors, axis-aligned
    push_req(0, 0, 0, 0, 0);
    push_req(100, 0, 0, 0, 0);
    push_req(-100, 0, 0, 0, 0);
    push_req(0, 100, 0, 0, 0);
    push_req(0, -100, 0, 0, 0);
    push_req(-100, -1, 0, 0, 0);
    push_req(-100, 1, 0, 0, 0);
    push_req(32767, 32767, 32767, 32767, 32767);
    push_req(-32768, -32768, -32768, -32768, -32768);
    push_req(0, 0, 500, 16384, 0);
    push_req(0, 0, 500, -16384, 0);
    push_req(300, 200, -400, 20000, -20000);
    push_req(-32768, 32767, -32768, 16383, -16383);
    push_req(32767, -32768, 32767, -16385, 16385);
    push_req(0, 0, 1000, 16384, 16384);
    push_req(1, 0, 0, 0, 0);
    push_req(-1, -1, 0, 0, 0);
    push_req(-32768, 0, 0, 0, 0);
    push_req(5, -7, 9, 8192, -8192);
    push_req(0, 1, 0, -32768, 32767);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int n = 0; n < 1750; n++) begin
      if ($urandom_range(0, 9) == 0)
        push_req(rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      else if ($urandom_range(0, 9) == 0)
        push_req(int'($urandom_range(0, 20)) - 10, int'($urandom_range(0, 20)) - 10,
                 int'($urandom_range(0, 20)) - 10, rnd_acc(), rnd_acc());
      else
        push_req(rnd16(), rnd16(), rnd16(), rnd_acc(), rnd_acc());
      if (n == 400) begin
        // receiver holds off while the sender keeps offering
        while (pend_q.size() > 200) @(posedge clk_i);
        hold_cycles = 300;
      end
      if (n == 900) begin
        while (pend_q.size() > 0) @(posedge clk_i);
        hold_req = 1'b1;
        while (heading_exp_q.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_req = 1'b0;
      end
    end
    while (pend_q.size() > 0 || in_valid_i) @(posedge clk_i);
    wait_cnt = 0;
    while (heading_exp_q.size() > 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0 && heading_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (heading_exp_q.size() != 0) report_err("results missing at end");
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tcch_pkg.sv
hw/rtl/tcch_sqrt_cell.sv
hw/rtl/tcch_cordic_cell.sv
hw/rtl/tilt_compensated_compass_heading_core.sv
hw/rtl/tcch_checker.sv
tb/sv/tb_top.sv
